FILE: design/hwj_pkg.sv
// Shared types and constants for the handshake window join node.
// No dependencies; used by every other file of the block.
package hwj_pkg;

    localparam int WIN_DEPTH = 16;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int WIN_CW    = $clog2(WIN_DEPTH + 1);

    localparam logic [1:0] FUNC_R   = 2'd0;
    localparam logic [1:0] FUNC_S   = 2'd1;
    localparam logic [1:0] FUNC_ACK = 2'd2;

    localparam logic [2:0] REG_WLEN  = 3'd0;
    localparam logic [2:0] REG_OFF_S = 3'd1;
    localparam logic [2:0] REG_OFF_R = 3'd2;
    localparam logic [2:0] REG_LEFT  = 3'd3;
    localparam logic [2:0] REG_RIGHT = 3'd4;

    typedef enum logic [1:0] {
        KIND_MATCH   = 2'd0,
        KIND_S_RIGHT = 2'd1,
        KIND_R_LEFT  = 2'd2,
        KIND_S_IND   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_R = 2'd0,
        ST_S = 2'd1,
        ST_F = 2'd2
    } t_store_id;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_CALC,
        S_EXP_OPP_RD,
        S_EXP_OPP_CHK,
        S_SCAN,
        S_PUSH,
        S_EXP_OWN_RD,
        S_EXP_OWN_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [WIN_AW-1:0] rd_idx;
        logic [63:0]       wr_data;
    } t_store_ctl;

    typedef struct packed {
        logic [WIN_CW-1:0] count;
        logic [63:0]       rd_data;
    } t_store_sts;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] key;
        logic [31:0] time_val;
        logic [5:0]  mc;
        logic        ovf;
    } t_result;

endpackage

FILE: design/handshake_window_join_node.sv
// Top level of the handshake window join node: configuration registers,
// result stage, sequencer and three tuple stores. Depends on hwj_pkg,
// hwj_store and hwj_ctrl.
//
// A request is taken when i_start is high and o_busy is low. Function R or S
// runs the sequence: expire the opposite window, count equal keys, store the
// tuple, expire its own window. An ack is taken without leaving idle and gives
// no result. Results appear one per cycle at most, each for one cycle with
// o_strobe high, and o_last marks the final result of a request. The receiver
// cannot stall. The last result is on the ports in the first cycle with o_busy
// low. Reset empties all stores and loads the register defaults; the user must
// write the configuration port only while the block is idle, and the block
// itself does not enforce this.
module handshake_window_join_node (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_tuple_key,
    input  logic [31:0] i_tuple_time,
    output logic        o_busy,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [31:0] o_out_key,
    output logic [31:0] o_out_time,
    output logic [5:0]  o_match_count,
    output logic        o_overflow,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_wlen;
    logic [31:0] r_off_s;
    logic [31:0] r_off_r;
    logic        r_has_left;
    logic        r_has_right;
    logic [2:0]  reg_idx;

    hwj_pkg::t_store_ctl ctl_r, ctl_s, ctl_f;
    hwj_pkg::t_store_sts sts_r, sts_s, sts_f;
    hwj_pkg::t_result    res;
    logic                emit, finish, busy;

    logic                r_pend_v;
    hwj_pkg::t_result    r_pend;
    logic                r_out_v;
    hwj_pkg::t_result    r_out;
    logic                r_out_last;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen      <= 32'd1000;
            r_off_s     <= '0;
            r_off_r     <= '0;
            r_has_left  <= 1'b0;
            r_has_right <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                hwj_pkg::REG_WLEN:  r_wlen      <= pwdata;
                hwj_pkg::REG_OFF_S: r_off_s     <= pwdata;
                hwj_pkg::REG_OFF_R: r_off_r     <= pwdata;
                hwj_pkg::REG_LEFT:  r_has_left  <= pwdata[0];
                hwj_pkg::REG_RIGHT: r_has_right <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            hwj_pkg::REG_WLEN:  prdata = r_wlen;
            hwj_pkg::REG_OFF_S: prdata = r_off_s;
            hwj_pkg::REG_OFF_R: prdata = r_off_r;
            hwj_pkg::REG_LEFT:  prdata = {31'd0, r_has_left};
            hwj_pkg::REG_RIGHT: prdata = {31'd0, r_has_right};
            default:            prdata = '0;
        endcase
    end

    hwj_store u_store_r (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_r), .o_sts(sts_r));
    hwj_store u_store_s (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_s), .o_sts(sts_s));
    hwj_store u_store_f (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_f), .o_sts(sts_f));

    hwj_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_start && !busy),
        .i_func      (i_func),
        .i_key       (i_tuple_key),
        .i_time      (i_tuple_time),
        .i_wlen      (r_wlen),
        .i_off_s     (r_off_s),
        .i_off_r     (r_off_r),
        .i_has_left  (r_has_left),
        .i_has_right (r_has_right),
        .i_sts_r     (sts_r),
        .i_sts_s     (sts_s),
        .i_sts_f     (sts_f),
        .o_ctl_r     (ctl_r),
        .o_ctl_s     (ctl_s),
        .o_ctl_f     (ctl_f),
        .o_busy      (busy),
        .o_emit      (emit),
        .o_res       (res),
        .o_finish    (finish)
    );

    // A result is held back in r_pend so that the final one can carry the last flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else if (emit) begin
            r_out_v  <= r_pend_v;
            r_pend_v <= 1'b1;
        end else if (finish) begin
            r_out_v  <= r_pend_v;
            r_pend_v <= 1'b0;
        end else begin
            r_out_v  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out      <= r_pend;
            r_out_last <= 1'b0;
            r_pend     <= res;
        end else if (finish) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    assign o_busy        = busy;
    assign o_strobe      = r_out_v;
    assign o_kind        = r_out.kind;
    assign o_out_key     = r_out.key;
    assign o_out_time    = r_out.time_val;
    assign o_match_count = r_out.mc;
    assign o_overflow    = r_out.ovf;
    assign o_last        = r_out_last;

endmodule

FILE: design/hwj_store.sv
// One time-ordered tuple store: a synchronous memory with head and fill count.
// Depends on hwj_pkg.
module hwj_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hwj_pkg::t_store_ctl i_ctl,
    output hwj_pkg::t_store_sts o_sts
);

    logic [63:0]                 r_mem [hwj_pkg::WIN_DEPTH];
    logic [hwj_pkg::WIN_AW-1:0]  r_head;
    logic [hwj_pkg::WIN_CW-1:0]  r_count;
    logic [63:0]                 r_rd_data;
    logic [hwj_pkg::WIN_AW-1:0]  rd_addr;
    logic [hwj_pkg::WIN_AW-1:0]  wr_addr;

    assign rd_addr = r_head + i_ctl.rd_idx;
    assign wr_addr = r_head + r_count[hwj_pkg::WIN_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[wr_addr] <= i_ctl.wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.pop) begin
                r_head <= r_head + 1'b1;
            end
            r_count <= r_count + hwj_pkg::WIN_CW'(i_ctl.push) - hwj_pkg::WIN_CW'(i_ctl.pop);
        end
    end

    assign o_sts.count   = r_count;
    assign o_sts.rd_data = r_rd_data;

endmodule

FILE: design/hwj_ctrl.sv
// Sequencer of the join node: expiry, key scan, store and result requests.
// Depends on hwj_pkg; drives three hwj_store instances.
module hwj_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_func,
    input  logic [31:0]         i_key,
    input  logic [31:0]         i_time,
    input  logic [31:0]         i_wlen,
    input  logic [31:0]         i_off_s,
    input  logic [31:0]         i_off_r,
    input  logic                i_has_left,
    input  logic                i_has_right,
    input  hwj_pkg::t_store_sts i_sts_r,
    input  hwj_pkg::t_store_sts i_sts_s,
    input  hwj_pkg::t_store_sts i_sts_f,
    output hwj_pkg::t_store_ctl o_ctl_r,
    output hwj_pkg::t_store_ctl o_ctl_s,
    output hwj_pkg::t_store_ctl o_ctl_f,
    output logic                o_busy,
    output logic                o_emit,
    output hwj_pkg::t_result    o_res,
    output logic                o_finish
);

    hwj_pkg::t_state    r_state, n_state;
    logic               r_is_s;
    logic [31:0]        r_key;
    logic [31:0]        r_time;
    logic               r_cond_ok;
    logic [32:0]        r_cond;
    logic [32:0]        r_start_opp;
    logic [32:0]        r_start_own;
    hwj_pkg::t_store_id r_sel;
    logic [hwj_pkg::WIN_CW-1:0] r_idx;
    logic               r_pend;
    logic [5:0]         r_mc;

    hwj_pkg::t_store_id opp_id, own_id;
    hwj_pkg::t_store_sts opp_sts, own_sts, sel_sts;
    logic [32:0]        sum_own;
    logic [32:0]        off_other;
    logic               opp_exp, own_exp, scan_end, scan_hit, own_full;

    function automatic hwj_pkg::t_store_sts pick(input hwj_pkg::t_store_id id,
                                                 input hwj_pkg::t_store_sts sr,
                                                 input hwj_pkg::t_store_sts ss,
                                                 input hwj_pkg::t_store_sts sf);
        hwj_pkg::t_store_sts res;
        unique case (id)
            hwj_pkg::ST_R: res = sr;
            hwj_pkg::ST_S: res = ss;
            default:       res = sf;
        endcase
        return res;
    endfunction

    assign opp_id  = r_is_s ? hwj_pkg::ST_R : hwj_pkg::ST_S;
    assign own_id  = r_is_s ? hwj_pkg::ST_S : hwj_pkg::ST_R;
    assign opp_sts = pick(opp_id, i_sts_r, i_sts_s, i_sts_f);
    assign own_sts = pick(own_id, i_sts_r, i_sts_s, i_sts_f);
    assign sel_sts = pick(r_sel, i_sts_r, i_sts_s, i_sts_f);

    assign sum_own   = {1'b0, r_time} + {1'b0, (r_is_s ? i_off_s : i_off_r)};
    assign off_other = {1'b0, (r_is_s ? i_off_r : i_off_s)};
    assign opp_exp   = {1'b0, opp_sts.rd_data[31:0]} < r_start_opp;
    assign own_exp   = {1'b0, own_sts.rd_data[31:0]} < r_start_own;
    assign scan_end  = (r_idx == sel_sts.count) && !r_pend;
    assign scan_hit  = r_pend && (sel_sts.rd_data[63:32] == r_key);
    assign own_full  = own_sts.count == hwj_pkg::WIN_CW'(hwj_pkg::WIN_DEPTH);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hwj_pkg::S_IDLE: begin
                if (i_accept && (i_func == hwj_pkg::FUNC_R || i_func == hwj_pkg::FUNC_S)) begin
                    n_state = hwj_pkg::S_PREP;
                end
            end
            hwj_pkg::S_PREP: n_state = hwj_pkg::S_CALC;
            hwj_pkg::S_CALC: n_state = r_cond_ok ? hwj_pkg::S_EXP_OPP_RD : hwj_pkg::S_SCAN;
            hwj_pkg::S_EXP_OPP_RD: begin
                n_state = (opp_sts.count == '0) ? hwj_pkg::S_SCAN : hwj_pkg::S_EXP_OPP_CHK;
            end
            hwj_pkg::S_EXP_OPP_CHK: begin
                n_state = opp_exp ? hwj_pkg::S_EXP_OPP_RD : hwj_pkg::S_SCAN;
            end
            hwj_pkg::S_SCAN: begin
                if (scan_end && !(!r_is_s && r_sel == hwj_pkg::ST_S)) begin
                    n_state = hwj_pkg::S_PUSH;
                end
            end
            hwj_pkg::S_PUSH: n_state = hwj_pkg::S_EXP_OWN_RD;
            hwj_pkg::S_EXP_OWN_RD: begin
                n_state = (own_sts.count == '0) ? hwj_pkg::S_DONE : hwj_pkg::S_EXP_OWN_CHK;
            end
            hwj_pkg::S_EXP_OWN_CHK: begin
                n_state = own_exp ? hwj_pkg::S_EXP_OWN_RD : hwj_pkg::S_DONE;
            end
            hwj_pkg::S_DONE: n_state = hwj_pkg::S_IDLE;
            default: n_state = hwj_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        hwj_pkg::t_store_id exp_id;
        logic               exp_do;
        logic [63:0]        exp_data;

        o_ctl_r  = '0;
        o_ctl_s  = '0;
        o_ctl_f  = '0;
        o_emit   = 1'b0;
        o_res    = '0;
        o_finish = 1'b0;
        exp_id   = opp_id;
        exp_do   = 1'b0;
        exp_data = opp_sts.rd_data;

        unique case (r_state)
            hwj_pkg::S_IDLE: begin
                if (i_accept && i_func == hwj_pkg::FUNC_ACK && i_sts_f.count != '0) begin
                    o_ctl_f.pop = 1'b1;
                end
            end
            hwj_pkg::S_CALC: begin
                if (r_is_s && i_has_left) begin
                    o_emit     = 1'b1;
                    o_res.kind = hwj_pkg::KIND_S_IND;
                end
            end
            hwj_pkg::S_EXP_OPP_CHK: begin
                exp_do = opp_exp;
            end
            hwj_pkg::S_EXP_OWN_CHK: begin
                exp_id   = own_id;
                exp_do   = own_exp;
                exp_data = own_sts.rd_data;
            end
            hwj_pkg::S_SCAN: begin
                unique case (r_sel)
                    hwj_pkg::ST_R: o_ctl_r.rd_idx = r_idx[hwj_pkg::WIN_AW-1:0];
                    hwj_pkg::ST_S: o_ctl_s.rd_idx = r_idx[hwj_pkg::WIN_AW-1:0];
                    default:       o_ctl_f.rd_idx = r_idx[hwj_pkg::WIN_AW-1:0];
                endcase
            end
            hwj_pkg::S_PUSH: begin
                o_emit     = 1'b1;
                o_res.kind = hwj_pkg::KIND_MATCH;
                o_res.mc   = r_mc;
                o_res.ovf  = own_full;
                if (!own_full) begin
                    if (r_is_s) begin
                        o_ctl_s.push    = 1'b1;
                        o_ctl_s.wr_data = {r_key, r_time};
                    end else begin
                        o_ctl_r.push    = 1'b1;
                        o_ctl_r.wr_data = {r_key, r_time};
                    end
                end
            end
            default: begin
            end
        endcase

        if (exp_do) begin
            if (exp_id == hwj_pkg::ST_S) begin
                o_ctl_s.pop = 1'b1;
                if (i_has_right) begin
                    o_emit         = 1'b1;
                    o_res.kind     = hwj_pkg::KIND_S_RIGHT;
                    o_res.key      = exp_data[63:32];
                    o_res.time_val = exp_data[31:0];
                    o_res.ovf      = i_sts_f.count == hwj_pkg::WIN_CW'(hwj_pkg::WIN_DEPTH);
                    o_ctl_f.push    = !o_res.ovf;
                    o_ctl_f.wr_data = exp_data;
                end
            end else begin
                o_ctl_r.pop = 1'b1;
                if (i_has_left) begin
                    o_emit         = 1'b1;
                    o_res.kind     = hwj_pkg::KIND_R_LEFT;
                    o_res.key      = exp_data[63:32];
                    o_res.time_val = exp_data[31:0];
                end
            end
        end

        if (r_state == hwj_pkg::S_DONE) begin
            o_finish = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hwj_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hwj_pkg::S_IDLE && i_accept) begin
            r_is_s <= i_func == hwj_pkg::FUNC_S;
            r_key  <= i_key;
            r_time <= i_time;
        end
        if (r_state == hwj_pkg::S_PREP) begin
            r_cond_ok <= sum_own > off_other;
            r_cond    <= sum_own - off_other;
        end
        if (r_state == hwj_pkg::S_CALC) begin
            r_start_opp <= (r_cond < {1'b0, i_wlen}) ? '0 : r_cond - {1'b0, i_wlen};
            r_start_own <= (r_time < i_wlen) ? '0 : {1'b0, r_time - i_wlen};
            r_sel  <= opp_id;
            r_idx  <= '0;
            r_pend <= 1'b0;
            r_mc   <= '0;
        end
        if (r_state == hwj_pkg::S_SCAN) begin
            if (scan_hit) begin
                r_mc <= r_mc + 6'd1;
            end
            if (scan_end) begin
                r_sel <= hwj_pkg::ST_F;
                r_idx <= '0;
            end else if (r_idx != sel_sts.count) begin
                r_idx  <= r_idx + 1'b1;
                r_pend <= 1'b1;
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    assign o_busy = r_state != hwj_pkg::S_IDLE;

endmodule
